>>> hw/rtl/imu_accel_gyro_time_aligner_assert.svh
// Assertion macros for the IMU accel/gyro time aligner checker.
// Included by the checker module only; depends on nothing else.
`ifndef IMU_ACCEL_GYRO_TIME_ALIGNER_ASSERT_SVH
`define IMU_ACCEL_GYRO_TIME_ALIGNER_ASSERT_SVH

// Assert that a property holds on every clock edge out of reset.
`define IAGTA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Assert that after a condition the next cycle shows a consequence.
`define IAGTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/iagta_pkg.sv
// Shared types and constants for the IMU accel/gyro time aligner.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package iagta_pkg;
  localparam int unsigned TimeW = 40;
  localparam int unsigned AxisW = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned DupW  = 16;

  localparam logic [CmdW-1:0] CmdGyro  = 2'd0;
  localparam logic [CmdW-1:0] CmdAccel = 2'd1;
  localparam logic [CmdW-1:0] CmdImage = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_gyro;   // write input sample into gyro buffer
    logic load_accel;   // shift accel pair
    logic start_frame;  // evaluate image duplicate / latch frame time
    logic load_entry;   // read entry at idx into working registers
    logic div_start;    // load divider operands
    logic div_step;     // one restoring division step
    logic mul_start;    // start multiplies
    logic out_load;     // load output register
    logic end_frame;    // clear count and flag, record image
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dup;          // image is a duplicate
    logic empty;        // gyro buffer empty
    logic need_div;     // entry lies after the older accel time and at or before the newer one
    logic last;         // current entry is the last one
  } stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/iagta_ctrl.sv
// Controller state machine of the IMU accel/gyro time aligner.
// Depends on iagta_pkg.
`default_nettype none
module iagta_ctrl #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_cmd_i,
  output logic                   in_stall_o,
  input  wire logic              out_full_i,
  input  wire logic              out_take_i,
  input  wire iagta_pkg::stat_t  stat_i,
  output iagta_pkg::ctrl_t       ctrl_o,
  output logic                   busy_o
);
  import iagta_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StMul   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;
  localparam int unsigned CntW = $clog2(FRACTION_BITS + 2);

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign busy_o     = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctrl_o  = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          ctrl_o.store_gyro  = (in_cmd_i == CmdGyro);
          ctrl_o.load_accel  = (in_cmd_i == CmdAccel);
          ctrl_o.start_frame = (in_cmd_i == CmdImage);
          if (in_cmd_i == CmdImage) state_d = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.dup) begin
          state_d = StIdle;
        end else if (stat_i.empty) begin
          state_d = StOut;
        end else begin
          ctrl_o.load_entry = 1'b1;
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (stat_i.need_div) begin
          ctrl_o.div_start = 1'b1;
          cnt_d   = '0;
          state_d = StDiv;
        end else begin
          state_d = StOut;
        end
      end
      StDiv: begin
        ctrl_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(FRACTION_BITS - 1)) begin
          state_d = StMul;
          cnt_d   = '0;
        end
      end
      StMul: begin
        ctrl_o.mul_start = (cnt_q == '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(2)) state_d = StOut;
      end
      StOut: begin
        if (!out_full_i || out_take_i) begin
          ctrl_o.out_load = 1'b1;
          if (stat_i.empty || stat_i.last) begin
            ctrl_o.end_frame = 1'b1;
            state_d = StIdle;
          end else begin
            ctrl_o.load_entry = 1'b1;
            state_d = StLoad;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/iagta_dp.sv
// Datapath of the IMU accel/gyro time aligner: gyro buffer, accel pair,
// serial fraction divider, pipelined multiplies and output register.
// Depends on iagta_pkg.
`default_nettype none
module iagta_dp #(
  parameter int unsigned GYRO_DEPTH    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire iagta_pkg::ctrl_t   ctrl_i,
  output iagta_pkg::stat_t        stat_o,
  input  wire logic [15:0]        dup_window_i,
  input  wire logic [39:0]        time_i,
  input  wire logic signed [31:0] ax_i,
  input  wire logic signed [31:0] ay_i,
  input  wire logic signed [31:0] az_i,
  input  wire logic               out_take_i,
  output logic                    out_full_o,
  output logic [39:0]             frame_time_o,
  output logic [39:0]             sample_time_o,
  output logic signed [31:0]      accel_x_o,
  output logic signed [31:0]      accel_y_o,
  output logic signed [31:0]      accel_z_o,
  output logic signed [31:0]      rate_x_o,
  output logic signed [31:0]      rate_y_o,
  output logic signed [31:0]      rate_z_o,
  output logic                    sample_valid_o,
  output logic                    overflow_o,
  output logic                    last_o
);
  import iagta_pkg::*;

  localparam int unsigned IdxW = $clog2(GYRO_DEPTH);
  localparam int unsigned CntW = $clog2(GYRO_DEPTH + 1);
  localparam int unsigned EntW = TimeW + 3 * AxisW;
  localparam int unsigned FW   = FRACTION_BITS + 1;
  localparam int unsigned DW   = AxisW + 1;
  localparam int unsigned PW   = DW + FW;

  // Gyro buffer memory: one write port, one registered read port.
  logic [EntW-1:0] mem [GYRO_DEPTH];
  logic [EntW-1:0] rd_q;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            dropped_q;
  logic            cur_ok_q, prev_ok_q, image_seen_q;
  logic signed [AxisW-1:0] cur_q [3];
  logic signed [AxisW-1:0] prev_q [3];
  logic [TimeW-1:0] cur_t_q, prev_t_q, last_img_q, frame_t_q;
  logic             dup_q;
  logic             last_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.store_gyro && count_q < CntW'(GYRO_DEPTH)) begin
      mem[count_q[IdxW-1:0]] <= {time_i, ax_i, ay_i, az_i};
    end
    if (ctrl_i.load_entry) rd_q <= mem[rd_idx_q];
  end

  logic [TimeW-1:0] img_diff;
  assign img_diff = (time_i >= last_img_q) ? time_i - last_img_q : last_img_q - time_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      dropped_q    <= 1'b0;
      cur_ok_q     <= 1'b0;
      prev_ok_q    <= 1'b0;
      image_seen_q <= 1'b0;
      cur_t_q      <= '0;
      prev_t_q     <= '0;
      last_img_q   <= '0;
      rd_idx_q     <= '0;
      dup_q        <= 1'b0;
      last_q       <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        cur_q[k]  <= '0;
        prev_q[k] <= '0;
      end
    end else begin
      if (ctrl_i.store_gyro) begin
        if (count_q < CntW'(GYRO_DEPTH)) count_q <= count_q + 1'b1;
        else dropped_q <= 1'b1;
      end
      if (ctrl_i.load_accel) begin
        prev_q[0] <= cur_q[0];
        prev_q[1] <= cur_q[1];
        prev_q[2] <= cur_q[2];
        cur_q[0]  <= ax_i;
        cur_q[1]  <= ay_i;
        cur_q[2]  <= az_i;
        prev_t_q  <= cur_t_q;
        cur_t_q   <= time_i;
        prev_ok_q <= cur_ok_q;
        cur_ok_q  <= 1'b1;
      end
      if (ctrl_i.start_frame) begin
        dup_q    <= image_seen_q && (img_diff < TimeW'(dup_window_i));
        rd_idx_q <= '0;
      end
      if (ctrl_i.load_entry) begin
        last_q   <= ({1'b0, rd_idx_q} + 1'b1) == (IdxW+1)'(count_q);
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (ctrl_i.end_frame) begin
        count_q      <= '0;
        dropped_q    <= 1'b0;
        last_img_q   <= frame_t_q;
        image_seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start_frame) frame_t_q <= time_i;
  end

  // Entry fields.
  logic [TimeW-1:0]        e_t;
  logic signed [AxisW-1:0] e_x, e_y, e_z;
  assign {e_t, e_x, e_y, e_z} = rd_q;

  logic use_cur, use_prev;
  assign use_cur  = !prev_ok_q || (e_t > cur_t_q);
  assign use_prev = !use_cur && (e_t <= prev_t_q);

  assign stat_o.dup      = dup_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.need_div = !use_cur && !use_prev;
  assign stat_o.last     = last_q;

  // Restoring divider, one quotient bit per cycle. The numerator never
  // exceeds the denominator, so the integer quotient bit is set only when
  // the gyro time equals the current accel time.
  logic [TimeW:0]   rem_q;
  logic [TimeW-1:0] den_q;
  logic [FW-1:0]    quo_q;
  logic [TimeW:0]   rem_sh;
  logic [TimeW-1:0] num_w, den_w;
  assign rem_sh = {rem_q[TimeW-1:0], 1'b0};
  assign num_w  = e_t - prev_t_q;
  assign den_w  = cur_t_q - prev_t_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      if (num_w >= den_w) begin
        rem_q <= {1'b0, num_w - den_w};
        quo_q <= FW'(1);
      end else begin
        rem_q <= {1'b0, num_w};
        quo_q <= '0;
      end
      den_q <= den_w;
    end else if (ctrl_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[FW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[FW-2:0], 1'b0};
      end
    end
  end

  // Multiply stage: difference magnitudes registered, then products, then
  // the signed result.
  logic [DW-1:0]  mag_q [3];
  logic           neg_q [3];
  logic [PW-1:0]  prod_q [3];
  logic signed [AxisW-1:0] interp_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [DW-1:0] d;
      d = {prev_q[k][AxisW-1], prev_q[k]};
      d = {cur_q[k][AxisW-1], cur_q[k]} - d;
      if (ctrl_i.mul_start) begin
        neg_q[k] <= d[DW-1];
        mag_q[k] <= d[DW-1] ? DW'(-d) : DW'(d);
      end
      prod_q[k] <= mag_q[k] * PW'(quo_q);
      interp_q[k] <= neg_q[k]
          ? AxisW'(prev_q[k] - AxisW'(prod_q[k] >> FRACTION_BITS))
          : AxisW'(prev_q[k] + AxisW'(prod_q[k] >> FRACTION_BITS));
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_o <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_full_o <= 1'b1;
    end else if (out_take_i) begin
      out_full_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      frame_time_o <= frame_t_q;
      overflow_o   <= dropped_q;
      if (count_q == '0) begin
        sample_time_o  <= '0;
        accel_x_o      <= '0;
        accel_y_o      <= '0;
        accel_z_o      <= '0;
        rate_x_o       <= '0;
        rate_y_o       <= '0;
        rate_z_o       <= '0;
        sample_valid_o <= 1'b0;
        last_o         <= 1'b1;
      end else begin
        sample_time_o  <= e_t;
        rate_x_o       <= e_x;
        rate_y_o       <= e_y;
        rate_z_o       <= e_z;
        sample_valid_o <= 1'b1;
        last_o         <= last_q;
        if (use_cur) begin
          accel_x_o <= cur_q[0];
          accel_y_o <= cur_q[1];
          accel_z_o <= cur_q[2];
        end else if (use_prev) begin
          accel_x_o <= prev_q[0];
          accel_y_o <= prev_q[1];
          accel_z_o <= prev_q[2];
        end else begin
          accel_x_o <= interp_q[0];
          accel_y_o <= interp_q[1];
          accel_z_o <= interp_q[2];
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/imu_accel_gyro_time_aligner.sv
// Top level of the IMU accel/gyro time aligner.
// Depends on iagta_pkg, iagta_ctrl and iagta_dp.
`default_nettype none
// Gyro and accel beats produce nothing. An image beat is first checked for
// a duplicate, which produces nothing; otherwise every buffered gyro sample
// is read from the buffer memory, and a sample that falls after the older
// and at or before the newer of the two latest accel samples runs through a
// one-bit-per-cycle fraction divider and a three-stage multiply, while any
// other sample is clamped. An image with an empty buffer yields one marker
// beat with sample_valid low.
// The block handles one input beat at a time and stalls the input while an
// image is being processed; one output register holds each result beat.
// The duplicate window register takes writes whenever the block is idle.
module imu_accel_gyro_time_aligner #(
  parameter int unsigned GYRO_DEPTH    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [39:0]        time_us_i,
  input  wire logic signed [31:0] axis_x_i,
  input  wire logic signed [31:0] axis_y_i,
  input  wire logic signed [31:0] axis_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [39:0]             frame_time_us_o,
  output logic [39:0]             sample_time_us_o,
  output logic signed [31:0]      accel_x_o,
  output logic signed [31:0]      accel_y_o,
  output logic signed [31:0]      accel_z_o,
  output logic signed [31:0]      rate_x_o,
  output logic signed [31:0]      rate_y_o,
  output logic signed [31:0]      rate_z_o,
  output logic                    sample_valid_o,
  output logic                    overflow_o,
  output logic                    last_of_frame_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i
);
  import iagta_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  busy;
  logic  take;
  logic [15:0] dup_window_q;

  // The window register is only written while idle.
  assign cfg_ready_o = !busy;
  assign take        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_window_q <= 16'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dup_window_q <= cfg_data_i;
    end
  end

  iagta_ctrl #(.FRACTION_BITS(FRACTION_BITS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_cmd_i(command_i), .in_stall_o,
    .out_full_i(out_valid_o), .out_take_i(take),
    .stat_i(stat), .ctrl_o(ctrl), .busy_o(busy)
  );

  iagta_dp #(.GYRO_DEPTH(GYRO_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i(ctrl), .stat_o(stat), .dup_window_i(dup_window_q),
    .time_i(time_us_i), .ax_i(axis_x_i), .ay_i(axis_y_i), .az_i(axis_z_i),
    .out_take_i(take), .out_full_o(out_valid_o),
    .frame_time_o(frame_time_us_o), .sample_time_o(sample_time_us_o),
    .accel_x_o, .accel_y_o, .accel_z_o,
    .rate_x_o, .rate_y_o, .rate_z_o,
    .sample_valid_o, .overflow_o, .last_o(last_of_frame_o)
  );
endmodule
`default_nettype wire

>>> hw/rtl/iagta_checker.sv
// Port-level checker for the IMU accel/gyro time aligner, bound to the top.
// Depends on imu_accel_gyro_time_aligner_assert.svh.
`default_nettype none
`include "imu_accel_gyro_time_aligner_assert.svh"
module iagta_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        in_stall_o,
  input wire logic        sample_valid_o,
  input wire logic        last_of_frame_o,
  input wire logic [39:0] frame_time_us_o
);
  // A held result keeps its frame time.
  `IAGTA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                     out_valid_o && $stable(frame_time_us_o))
  // A marker beat is always the last of its frame.
  `IAGTA_ASSERT(a_marker_last, clk_i, rst_ni,
                !out_valid_o || sample_valid_o || last_of_frame_o)
  // Results only appear while an image is in progress or right after it.
  `IAGTA_ASSERT_NEXT(a_out_busy, clk_i, rst_ni, $rose(out_valid_o) && !last_of_frame_o,
                     in_stall_o)
endmodule
bind imu_accel_gyro_time_aligner iagta_checker u_chk (.*);
`default_nettype wire
